// ----- design/minv3_pkg.sv -----
// ----------------------------------------------------------------------------
// minv3_pkg
// Shared constants and index helpers for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package minv3_pkg;

  // entries in a 3x3 matrix
  localparam int N_ENT = 9;

  // position of the tuser flags on the result channel
  localparam int USER_SINGULAR  = 0;
  localparam int USER_SATURATED = 1;
  localparam int USER_W         = 2;

  // wrap a row or column index back into 0..2
  function automatic int wrap3(input int x);
    return (x > 2) ? x - 3 : x;
  endfunction

endpackage

// ----- design/matrix_inverse_3x3.sv -----
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Pipelined inverse of one signed fixed-point 3x3 matrix per item.
// ----------------------------------------------------------------------------
// The block takes one matrix per cycle and gives one inverse per cycle once
// the pipeline is full, while no result waits in the skid entry. Four stages
// form the cofactors and the determinant, one stage takes magnitudes, one
// stage per quotient bit runs a restoring long division in nine parallel
// lanes, one stage rounds and checks the range, and an output register with
// a skid entry feeds the result channel. A singular matrix gives zero
// entries with the singular flag set; saturated is set when any entry was
// clamped.
module matrix_inverse_3x3 #(
  parameter int IN_WIDTH  = 16,
  parameter int IN_FRAC   = 12,
  parameter int OUT_WIDTH = 32,
  parameter int OUT_FRAC  = 16
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           s_axis_tvalid,
  output logic                                           s_axis_tready,
  // m11, m12, m13, m21, m22, m23, m31, m32, m33
  input  logic [((minv3_pkg::N_ENT*IN_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  input  logic                                           s_axis_tlast,
  output logic                                           m_axis_tvalid,
  input  logic                                           m_axis_tready,
  // r11, r12, r13, r21, r22, r23, r31, r32, r33
  output logic [((minv3_pkg::N_ENT*OUT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // singular, saturated
  output logic [minv3_pkg::USER_W-1:0]                   m_axis_tuser,
  output logic                                           m_axis_tlast
);

  localparam int NE         = minv3_pkg::N_ENT;
  localparam int OUT_DATA_W = ((NE*OUT_WIDTH+7)/8)*8;
  localparam int PW         = 2*IN_WIDTH;
  localparam int CW         = PW + 1;
  localparam int DPW        = IN_WIDTH + CW;
  localparam int DW         = DPW + 2;
  localparam int SH         = IN_FRAC + OUT_FRAC;
  localparam int NB         = CW + SH;
  localparam int QW         = OUT_WIDTH + 1;
  localparam int RW         = DW + 1;
  localparam logic [QW:0]          LIM  = (QW+1)'(1) << (OUT_WIDTH-1);
  localparam logic [OUT_WIDTH-1:0] MAXV = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam logic [OUT_WIDTH-1:0] MINV = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  logic en;
  logic skid_valid;

  assign en            = !skid_valid;
  assign s_axis_tready = en;

  logic signed [IN_WIDTH-1:0] m_in [NE];

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      m_in[k] = s_axis_tdata[k*IN_WIDTH +: IN_WIDTH];
    end
  end

  // --- front stages: products, cofactors, determinant terms, determinant
  logic                       v0, v1, v2, v3;
  logic signed [PW-1:0]       pa [NE];
  logic signed [PW-1:0]       pb [NE];
  logic signed [IN_WIDTH-1:0] m1_s0 [3];
  logic signed [IN_WIDTH-1:0] m1_s1 [3];
  logic signed [CW-1:0]       cof_s1 [NE];
  logic signed [CW-1:0]       cof_s2 [NE];
  logic signed [CW-1:0]       cof_s3 [NE];
  logic signed [DPW-1:0]      dp [3];
  logic signed [DW-1:0]       det;
  logic                       last_s0, last_s1, last_s2, last_s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // lane i*3+j is the cofactor of entry (j,i)
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pa[i*3+j] <= PW'(m_in[minv3_pkg::wrap3(j+1)*3 + minv3_pkg::wrap3(i+1)])
                     * PW'(m_in[minv3_pkg::wrap3(j+2)*3 + minv3_pkg::wrap3(i+2)]);
          pb[i*3+j] <= PW'(m_in[minv3_pkg::wrap3(j+1)*3 + minv3_pkg::wrap3(i+2)])
                     * PW'(m_in[minv3_pkg::wrap3(j+2)*3 + minv3_pkg::wrap3(i+1)]);
        end
      end
      for (int c = 0; c < 3; c++) begin
        m1_s0[c] <= m_in[c];
        m1_s1[c] <= m1_s0[c];
        dp[c]    <= DPW'(m1_s1[c]) * DPW'(cof_s1[c*3]);
      end
      for (int o = 0; o < NE; o++) begin
        cof_s1[o] <= CW'(pa[o]) - CW'(pb[o]);
        cof_s2[o] <= cof_s1[o];
        cof_s3[o] <= cof_s2[o];
      end
      det     <= DW'(dp[0]) + DW'(dp[1]) + DW'(dp[2]);
      last_s0 <= s_axis_tlast;
      last_s1 <= last_s0;
      last_s2 <= last_s1;
      last_s3 <= last_s2;
    end
  end

  // --- long division, one quotient bit per stage; index 0 holds magnitudes
  logic            dv   [NB+1];
  logic [DW-1:0]   dd   [NB+1];
  logic            dz   [NB+1];
  logic            dl   [NB+1];
  logic [CW-1:0]   nn   [NB+1][NE];
  logic [DW-1:0]   rr   [NB+1][NE];
  logic [QW-1:0]   qq   [NB+1][NE];
  logic            st   [NB+1][NE];
  logic            sg   [NB+1][NE];
  logic [RW-1:0]   tr   [NB][NE];
  logic [RW-1:0]   rs   [NB][NE];
  logic            ge   [NB][NE];

  always_comb begin
    for (int k = 0; k < NB; k++) begin
      for (int o = 0; o < NE; o++) begin
        tr[k][o] = {rr[k][o], nn[k][o][CW-1]};
        rs[k][o] = tr[k][o] - {1'b0, dd[k]};
        ge[k][o] = tr[k][o] >= {1'b0, dd[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NB; k++) begin
        dv[k] <= 1'b0;
      end
    end else if (en) begin
      dv[0] <= v3;
      for (int k = 0; k < NB; k++) begin
        dv[k+1] <= dv[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= det[DW-1] ? DW'(-det) : DW'(det);
      dz[0] <= det == '0;
      dl[0] <= last_s3;
      for (int o = 0; o < NE; o++) begin
        nn[0][o] <= cof_s3[o][CW-1] ? CW'(-cof_s3[o]) : CW'(cof_s3[o]);
        rr[0][o] <= '0;
        qq[0][o] <= '0;
        st[0][o] <= 1'b0;
        sg[0][o] <= cof_s3[o][CW-1] ^ det[DW-1];
      end
      for (int k = 0; k < NB; k++) begin
        dd[k+1] <= dd[k];
        dz[k+1] <= dz[k];
        dl[k+1] <= dl[k];
        for (int o = 0; o < NE; o++) begin
          nn[k+1][o] <= nn[k][o] << 1;
          rr[k+1][o] <= ge[k][o] ? rs[k][o][DW-1:0] : tr[k][o][DW-1:0];
          qq[k+1][o] <= {qq[k][o][QW-2:0], ge[k][o]};
          // any bit pushed off the top means the quotient is out of range
          st[k+1][o] <= st[k][o] | qq[k][o][QW-1];
          sg[k+1][o] <= sg[k][o];
        end
      end
    end
  end

  // --- round half away from zero on the magnitude, check range
  logic            rnd  [NE];
  logic [QW:0]     mq   [NE];
  logic            ovr  [NE];
  logic            fv, fz, fl;
  logic [OUT_WIDTH-1:0] fmag [NE];
  logic            fovr [NE];
  logic            fsg  [NE];

  always_comb begin
    for (int o = 0; o < NE; o++) begin
      rnd[o] = {rr[NB][o], 1'b0} >= {1'b0, dd[NB]};
      mq[o]  = {1'b0, qq[NB][o]} + (QW+1)'(rnd[o]);
      ovr[o] = st[NB][o] | (mq[o] > (sg[NB][o] ? LIM : LIM - 1'b1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= dv[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fz <= dz[NB];
      fl <= dl[NB];
      for (int o = 0; o < NE; o++) begin
        fmag[o] <= mq[o][OUT_WIDTH-1:0];
        fovr[o] <= ovr[o];
        fsg[o]  <= sg[NB][o];
      end
    end
  end

  logic [OUT_DATA_W-1:0] p_data;
  logic [minv3_pkg::USER_W-1:0] p_user;
  logic                  any_ovr;

  always_comb begin
    p_data  = '0;
    any_ovr = 1'b0;
    for (int o = 0; o < NE; o++) begin
      any_ovr = any_ovr | fovr[o];
      if (fz) begin
        p_data[o*OUT_WIDTH +: OUT_WIDTH] = '0;
      end else if (fovr[o]) begin
        p_data[o*OUT_WIDTH +: OUT_WIDTH] = fsg[o] ? MINV : MAXV;
      end else begin
        p_data[o*OUT_WIDTH +: OUT_WIDTH] = fsg[o] ? ~fmag[o] + 1'b1 : fmag[o];
      end
    end
    p_user = '0;
    p_user[minv3_pkg::USER_SINGULAR]  = fz;
    p_user[minv3_pkg::USER_SATURATED] = !fz && any_ovr;
  end

  // --- output register with skid entry
  logic                         out_valid;
  logic [OUT_DATA_W-1:0]        out_data, skid_data;
  logic [minv3_pkg::USER_W-1:0] out_user, skid_user;
  logic                         out_last, skid_last;
  logic                         incoming;

  assign incoming = en && fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= incoming;
      end
    end else if (incoming) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
        out_user <= skid_user;
        out_last <= skid_last;
      end else begin
        out_data <= p_data;
        out_user <= p_user;
        out_last <= fl;
      end
    end else if (incoming) begin
      // hold the new item while the current one waits
      skid_data <= p_data;
      skid_user <= p_user;
      skid_last <= fl;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;
  assign m_axis_tlast  = out_last;

endmodule

// ----- design/minv3_checker.sv -----
// ----------------------------------------------------------------------------
// minv3_checker
// Port-level checks for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
module minv3_checker #(
  parameter int OUT_DW = 288
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [OUT_DW-1:0]             m_axis_tdata,
  input logic [minv3_pkg::USER_W-1:0]  m_axis_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[minv3_pkg::USER_SINGULAR] |->
      m_axis_tdata == '0 && !m_axis_tuser[minv3_pkg::USER_SATURATED])
    else $error("singular result with nonzero entries or saturation");

  a_backpressure_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

endmodule

bind matrix_inverse_3x3 minv3_checker #(
  .OUT_DW(OUT_DATA_W)
) u_minv3_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
